// File: hdl/fractional_delay_line_macros.svh
// Assertion macros shared by the fractional delay line RTL.
// Depends on clk_i and rst_ni being present in the module that uses them.
`ifndef FRACTIONAL_DELAY_LINE_MACROS_SVH
`define FRACTIONAL_DELAY_LINE_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define FDL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// When the trigger holds, the consequence must hold in the next cycle.
`define FDL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/fdl_pkg.sv
// Shared widths, defaults, register codes and types of the fractional delay line.
// No dependencies.
package fdl_pkg;

  localparam int SAMPLE_W        = 24;
  localparam int DELAY_W         = 18;
  localparam int FRAC_W          = 8;
  localparam int PLACE_W         = DELAY_W - FRAC_W + 1;
  localparam int LINE_LENGTH_DEF = 1023;
  localparam int PADDR_W         = 3;
  localparam int PDATA_W         = 32;

  localparam logic REG_DELAY = 1'b0;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } store_ctrl_t;

endpackage

// File: hdl/fdl_store.sv
// Sample store of the fractional delay line: one write port, two registered read ports.
// Depends on fdl_pkg.
module fdl_store #(
  parameter int DEPTH  = fdl_pkg::LINE_LENGTH_DEF + 1,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                                clk_i,
  input  fdl_pkg::store_ctrl_t                ctrl_i,
  input  logic [ADDR_W-1:0]                   waddr_i,
  input  logic signed [fdl_pkg::SAMPLE_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0]                   raddr_a_i,
  input  logic [ADDR_W-1:0]                   raddr_b_i,
  output logic signed [fdl_pkg::SAMPLE_W-1:0] rdata_a_o,
  output logic signed [fdl_pkg::SAMPLE_W-1:0] rdata_b_o
);

  logic signed [fdl_pkg::SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

// File: hdl/fractional_delay_line.sv
// Fractional delay line with linear interpolation between two stored samples.
// Input channel: in_valid_i, in_ready_o, sample_in_i (one signed 24-bit sample per item).
// Output channel: out_valid_o, out_ready_i, sample_out_o (one result item per input item).
// Configuration: APB-style port, register 0 at byte address 0 holds the delay setting
// (18 bits, 8 fractional). A delay of LINE_LENGTH-1 samples or more acts as zero.
// Each item writes its sample into the store and reads the two neighbors in the same
// cycle; the store has one write port and two read ports, so one item is taken per cycle
// while the output does not stall. An item is registered in each stage in turn.
// The pipeline has four stages, each with its own valid bit; a stage advances when the
// next one is empty or advancing, so a stalled receiver fills the stages one by one and
// in_ready_o drops only when all four hold an item.
// Reset clears the delay setting, the write position and a fill counter. Store entries
// that have not been written since reset read as zero through that counter, so there is
// no clearing pass and an item may be accepted in the first cycle after reset.
// Depends on fdl_pkg, fdl_store and fractional_delay_line_macros.svh.
`include "fractional_delay_line_macros.svh"

module fractional_delay_line #(
  parameter int LINE_LENGTH = fdl_pkg::LINE_LENGTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [fdl_pkg::SAMPLE_W-1:0] sample_in_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [fdl_pkg::SAMPLE_W-1:0] sample_out_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fdl_pkg::PADDR_W-1:0]         paddr,
  input  logic [fdl_pkg::PDATA_W-1:0]         pwdata,
  output logic [fdl_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready
);

  localparam int N   = LINE_LENGTH + 1;
  localparam int AW  = $clog2(N);
  localparam int FW  = $clog2(N + 1);
  localparam int PW  = fdl_pkg::PLACE_W;
  localparam int CW  = (FW > PW) ? FW : PW;
  localparam int SW  = ((AW > PW) ? AW : PW) + 1;
  localparam int SMW = fdl_pkg::SAMPLE_W;
  localparam int DW  = fdl_pkg::DELAY_W;
  localparam int FRW = fdl_pkg::FRAC_W;
  localparam int MW  = SMW + 1 + FRW + 1;
  localparam int YW  = MW - FRW;

  localparam logic [31:0]   LIMIT    = 32'((LINE_LENGTH - 1) * 256);
  localparam logic [AW-1:0] LAST_POS = AW'(N - 1);
  localparam logic [FW-1:0] FULL     = FW'(N);
  localparam logic [SW-1:0] N_SW     = SW'(N);

  logic [DW-1:0] delay_q;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == fdl_pkg::REG_DELAY) ? fdl_pkg::PDATA_W'(delay_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= '0;
    end else if (cfg_wr && (paddr[2] == fdl_pkg::REG_DELAY)) begin
      delay_q <= pwdata[DW-1:0];
    end
  end

  logic          ready1, ready2, ready3, ready4;
  logic          v1_q, v2_q, v3_q, v4_q;
  logic          in_accept;
  logic [AW-1:0] wp_q;
  logic [FW-1:0] fill_q;

  assign ready4     = !v4_q || out_ready_i;
  assign ready3     = !v3_q || ready4;
  assign ready2     = !v2_q || ready3;
  assign ready1     = !v1_q || ready2;
  assign in_ready_o = ready1;
  assign in_accept  = in_valid_i && ready1;

  logic           too_long;
  logic [DW-1:0]  d_eff;
  logic [PW-1:0]  place_i, place_j;
  logic [FRW-1:0] frac;
  logic [SW-1:0]  sum_i, sum_j, idx_i, idx_j;
  logic           vi, vj;

  always_comb begin
    too_long = 32'(delay_q) >= LIMIT;
    d_eff    = too_long ? '0 : delay_q;
    place_i  = PW'(d_eff[DW-1:FRW]);
    place_j  = place_i + 1'b1;
    frac     = d_eff[FRW-1:0];
    sum_i    = SW'(wp_q) + SW'(place_i);
    sum_j    = SW'(wp_q) + SW'(place_j);
    idx_i    = (sum_i >= N_SW) ? sum_i - N_SW : sum_i;
    idx_j    = (sum_j >= N_SW) ? sum_j - N_SW : sum_j;
    vi       = CW'(place_i) <= CW'(fill_q);
    vj       = CW'(place_j) <= CW'(fill_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      fill_q <= '0;
    end else if (in_accept) begin
      wp_q <= (wp_q == '0) ? LAST_POS : wp_q - 1'b1;
      if (fill_q != FULL) begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  fdl_pkg::store_ctrl_t    store_ctrl;
  logic signed [SMW-1:0]   rd_a, rd_b;

  assign store_ctrl.wr_en = in_accept;
  assign store_ctrl.rd_en = ready1;

  fdl_store #(
    .DEPTH  (N),
    .ADDR_W (AW)
  ) u_store (
    .clk_i     (clk_i),
    .ctrl_i    (store_ctrl),
    .waddr_i   (wp_q),
    .wdata_i   (sample_in_i),
    .raddr_a_i (idx_i[AW-1:0]),
    .raddr_b_i (idx_j[AW-1:0]),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  logic                  ipz1_q, vi1_q, vj1_q;
  logic [FRW-1:0]        frac1_q, frac2_q;
  logic signed [SMW-1:0] samp1_q;
  logic signed [SMW-1:0] si, sj, si2_q, si3_q;
  logic signed [SMW:0]   diff, diff2_q;
  logic signed [MW-1:0]  prod, prod3_q;
  logic signed [YW-1:0]  y;
  logic signed [SMW-1:0] out_q;

  always_comb begin
    si   = ipz1_q ? samp1_q : (vi1_q ? rd_a : '0);
    sj   = vj1_q ? rd_b : '0;
    diff = (SMW + 1)'(sj) - (SMW + 1)'(si);
    prod = $signed({1'b0, frac2_q}) * diff2_q;
    y    = YW'(si3_q) + $signed(prod3_q[MW-1:FRW]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (ready1) begin
        v1_q <= in_valid_i;
      end
      if (ready2) begin
        v2_q <= v1_q;
      end
      if (ready3) begin
        v3_q <= v2_q;
      end
      if (ready4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready1) begin
      ipz1_q  <= (place_i == '0);
      vi1_q   <= vi;
      vj1_q   <= vj;
      frac1_q <= frac;
      samp1_q <= sample_in_i;
    end
    if (ready2) begin
      si2_q   <= si;
      diff2_q <= diff;
      frac2_q <= frac1_q;
    end
    if (ready3) begin
      si3_q   <= si2_q;
      prod3_q <= prod;
    end
    if (ready4) begin
      out_q <= y[SMW-1:0];
    end
  end

  assign out_valid_o  = v4_q;
  assign sample_out_o = out_q;

  `FDL_ASSERT(a_fill_bound, fill_q <= FULL, "Fill count exceeds the store size.")
  `FDL_ASSERT(a_wp_bound, wp_q <= LAST_POS, "Write position lies outside the store.")
  `FDL_ASSERT_NEXT(a_wp_step, in_accept,
    wp_q == (($past(wp_q) == '0) ? LAST_POS : $past(wp_q) - 1'b1),
    "Write position did not step down after an accepted item.")
  `FDL_ASSERT(a_full_stall, (v1_q && v2_q && v3_q && v4_q && !out_ready_i) |-> !in_ready_o,
    "Input taken while every stage holds an item and the output is stalled.")

endmodule

// File: dv/tb.sv
// Self-checking testbench for the fractional delay line: directed rows, then random
// delay phases with bursty input, a stalling output and an APB readback of the delay.
// Depends on fdl_pkg and the fractional_delay_line RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W = fdl_pkg::SAMPLE_W;
  localparam int DELAY_W = fdl_pkg::DELAY_W;
  localparam int FRAC_W = fdl_pkg::FRAC_W;
  localparam int PADDR_W = fdl_pkg::PADDR_W;
  localparam int PDATA_W = fdl_pkg::PDATA_W;
  localparam logic REG_DELAY = fdl_pkg::REG_DELAY;

  localparam int LINE_LENGTH = fdl_pkg::LINE_LENGTH_DEF;
  localparam int STORE_SIZE = LINE_LENGTH + 1;
  localparam int LONG_LIMIT = (LINE_LENGTH - 1) << FRAC_W;
  localparam int PIPE_LATENCY = 4;
  localparam int RANDOM_ITEMS = 1250;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_AFTER = 400;
  localparam int DIRECTED_COUNT = 20;
  localparam logic [PADDR_W-1:0] DELAY_ADDR = {REG_DELAY, 2'b00};
  localparam logic [PADDR_W-1:0] SPARE_ADDR = {~REG_DELAY, 2'b00};

  typedef struct packed {
    logic                wr_cfg;
    logic [PADDR_W-1:0]  addr;
    logic [DELAY_W-1:0]  delay;
    logic [SAMPLE_W-1:0] sample;
    logic                known;
    logic [SAMPLE_W-1:0] result;
  } stim_row_t;

  localparam stim_row_t DIRECTED [DIRECTED_COUNT] = '{
    '{1'b0, DELAY_ADDR, 18'h00000, 24'h000000, 1'b1, 24'h000000},
    '{1'b0, DELAY_ADDR, 18'h00000, 24'h7FFFFF, 1'b1, 24'h7FFFFF},
    '{1'b0, DELAY_ADDR, 18'h00000, 24'h800000, 1'b1, 24'h800000},
    '{1'b0, DELAY_ADDR, 18'h00000, 24'hFFFFFF, 1'b1, 24'hFFFFFF},
    '{1'b0, DELAY_ADDR, 18'h00000, 24'h000001, 1'b1, 24'h000001},
    '{1'b1, DELAY_ADDR, 18'h00080, 24'h000064, 1'b0, 24'h000000},
    '{1'b0, DELAY_ADDR, 18'h00080, 24'h800000, 1'b0, 24'h000000},
    '{1'b0, DELAY_ADDR, 18'h00080, 24'h7FFFFF, 1'b0, 24'h000000},
    '{1'b1, DELAY_ADDR, 18'h000FF, 24'h800000, 1'b0, 24'h000000},
    '{1'b0, DELAY_ADDR, 18'h000FF, 24'h7FFFFF, 1'b0, 24'h000000},
    '{1'b0, DELAY_ADDR, 18'h000FF, 24'hFFFFFF, 1'b0, 24'h000000},
    '{1'b1, DELAY_ADDR, 18'h00100, 24'h123456, 1'b1, 24'hFFFFFF},
    '{1'b1, DELAY_ADDR, 18'h3FCFF, 24'h0ABCDE, 1'b1, 24'h000000},
    '{1'b1, DELAY_ADDR, 18'h3FE00, 24'h654321, 1'b1, 24'h654321},
    '{1'b1, DELAY_ADDR, 18'h3FFFF, 24'h9ABCDE, 1'b1, 24'h9ABCDE},
    '{1'b1, SPARE_ADDR, 18'h00100, 24'h13579B, 1'b1, 24'h13579B},
    '{1'b1, DELAY_ADDR, 18'h00201, 24'h000010, 1'b0, 24'h000000},
    '{1'b0, DELAY_ADDR, 18'h00201, 24'hFFFF00, 1'b0, 24'h000000},
    '{1'b1, DELAY_ADDR, 18'h2AAAA, 24'h555555, 1'b0, 24'h000000},
    '{1'b1, DELAY_ADDR, 18'h15555, 24'hAAAAAA, 1'b0, 24'h000000}
  };

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic signed [SAMPLE_W-1:0] sample_in_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out_o;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [PADDR_W-1:0]         paddr = '0;
  logic [PDATA_W-1:0]         pwdata = '0;
  logic [PDATA_W-1:0]         prdata;
  logic                       pready;

  logic signed [SAMPLE_W-1:0] line_mem [STORE_SIZE];
  int unsigned                write_pos = 0;
  logic [DELAY_W-1:0]         delay_setting = '0;
  logic signed [SAMPLE_W-1:0] pending_samples [$];
  int unsigned                samples_accepted = 0;
  int unsigned                mismatches = 0;
  int unsigned                cycle_count = 0;

  fractional_delay_line dut (.*);

  always #5ns clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic count_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] delayed_sample(
    input logic signed [SAMPLE_W-1:0] s
  );
    int unsigned d, places, frac, next_places;
    longint near_val, far_val, step;
    d = (delay_setting >= LONG_LIMIT) ? 0 : delay_setting;
    places = d >> FRAC_W;
    frac = d & ((1 << FRAC_W) - 1);
    next_places = (places + 1) % STORE_SIZE;
    line_mem[write_pos] = s;
    near_val = longint'(line_mem[(write_pos + places) % STORE_SIZE]);
    far_val = longint'(line_mem[(write_pos + next_places) % STORE_SIZE]);
    step = (longint'(frac) * (far_val - near_val)) >>> FRAC_W;
    write_pos = (write_pos == 0) ? STORE_SIZE - 1 : write_pos - 1;
    return SAMPLE_W'(near_val + step);
  endfunction

  task automatic offer(input logic signed [SAMPLE_W-1:0] s, input bit known,
                       input logic signed [SAMPLE_W-1:0] typed);
    logic signed [SAMPLE_W-1:0] predicted;
    in_valid_i <= 1'b1;
    sample_in_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = delayed_sample(s);
    pending_samples.push_back(known ? typed : predicted);
    samples_accepted++;
    @(negedge clk_i);
  endtask

  task automatic pause_input(input int unsigned cycles);
    if (cycles != 0) begin
      in_valid_i <= 1'b0;
      repeat (cycles) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_samples.size() != 0) @(negedge clk_i);
    repeat (PIPE_LATENCY) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [PADDR_W-1:0] addr,
                                input logic [PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr[PADDR_W-1:2] == REG_DELAY) delay_setting = data[DELAY_W-1:0];
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= DELAY_ADDR;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== PDATA_W'(delay_setting))
      count_mismatch($sformatf("delay readback: expected %0h, got %0h",
                               delay_setting, prdata));
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_samples.size() == 0) begin
        count_mismatch($sformatf("unexpected sample_out %0d", sample_out_o));
      end else begin
        if (sample_out_o !== pending_samples[0])
          count_mismatch($sformatf("sample_out: expected %0d, got %0d",
                                   pending_samples[0], sample_out_o));
        void'(pending_samples.pop_front());
      end
    end
  end

  initial begin
    int unsigned span, mode, hold;
    bit held;
    held = 1'b0;
    hold = 0;
    @(posedge rst_ni);
    forever begin
      span = $urandom_range(20, 200);
      mode = $urandom_range(0, 2);
      repeat (span) begin
        @(negedge clk_i);
        if (!held && samples_accepted >= HOLD_AFTER) begin
          held = 1'b1;
          hold = 150;
        end
        if (hold != 0) begin
          hold--;
          out_ready_i <= 1'b0;
        end else begin
          case (mode)
            0: out_ready_i <= 1'b1;
            1: out_ready_i <= ($urandom_range(0, 3) != 0);
            default: out_ready_i <= ($urandom_range(0, 3) == 0);
          endcase
        end
      end
    end
  end

  initial begin
    int unsigned phase_len, burst_left;
    logic [DELAY_W-1:0] dly;
    logic signed [SAMPLE_W-1:0] s;
    foreach (line_mem[k]) line_mem[k] = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int k = 0; k < DIRECTED_COUNT; k++) begin
      if (DIRECTED[k].wr_cfg) begin
        drain();
        write_register(DIRECTED[k].addr, PDATA_W'(DIRECTED[k].delay));
      end
      offer(DIRECTED[k].sample, DIRECTED[k].known, DIRECTED[k].result);
      pause_input($urandom_range(0, 1));
    end

    while (samples_accepted < DIRECTED_COUNT + RANDOM_ITEMS) begin
      drain();
      case ($urandom_range(0, 9))
        0: dly = DELAY_W'($urandom_range(LONG_LIMIT, (1 << DELAY_W) - 1));
        1: dly = DELAY_W'(LONG_LIMIT - 1);
        2: dly = DELAY_W'($urandom_range(0, 1023));
        default: dly = DELAY_W'($urandom_range(0, LONG_LIMIT - 1));
      endcase
      write_register(DELAY_ADDR, PDATA_W'(dly));
      if ($urandom_range(0, 7) == 0)
        write_register(SPARE_ADDR, PDATA_W'($urandom_range(0, (1 << DELAY_W) - 1)));
      phase_len = $urandom_range(60, 140);
      burst_left = $urandom_range(1, 20);
      repeat (phase_len) begin
        case ($urandom_range(0, 7))
          0: s = $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
          1: s = SAMPLE_W'(int'($urandom_range(0, 32)) - 16);
          default: s = SAMPLE_W'($urandom());
        endcase
        offer(s, 1'b0, '0);
        burst_left--;
        if (burst_left == 0) begin
          pause_input(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
          burst_left = $urandom_range(1, 20);
        end
      end
    end

    drain();
    repeat (PIPE_LATENCY) @(negedge clk_i);
    if (mismatches == 0 && pending_samples.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
